// ===== rtl/core/pts_pkg.sv =====
// Shared types, widths and status codes for the priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

   localparam int TASK_SLOTS_DEF = 16;

   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int TIME_W   = 32;
   localparam int BURST_W  = 16;
   localparam int STATUS_W = 3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RAN    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd4;

   // request kinds
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
   } slot_entry_type;

   // one scanned slot as seen by the picker
   typedef struct packed {
      logic               vld;
      logic [PRIO_W-1:0]  prio;
      logic [TIME_W-1:0]  age;
   } cand_type;

endpackage

`default_nettype wire

// ===== rtl/core/pts_picker.sv =====
// Running best-slot selection over a slot scan in increasing slot order.
`timescale 1ns / 1ps
`default_nettype none

module pts_picker
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire logic                          cand_en,
   input  wire cand_type                      cand,
   input  wire logic [$clog2(TASK_SLOTS)-1:0] cand_slot,
   output logic                               best_found,
   output logic [PRIO_W-1:0]                  best_prio,
   output logic [$clog2(TASK_SLOTS)-1:0]      best_slot
);

   localparam int IDX_W = $clog2(TASK_SLOTS);

   logic              found_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0] age_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic              take;

   // ties on priority and age keep the earlier (lower) slot
   always_comb begin
      take = 1'b0;
      if (cand_en && cand.vld) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (cand.prio < prio_ff) begin
            take = 1'b1;
         end else if (cand.prio == prio_ff && cand.age > age_ff) begin
            take = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prio_ff <= cand.prio;
         age_ff  <= cand.age;
         slot_ff <= cand_slot;
      end
   end

   assign best_found = found_ff;
   assign best_prio  = prio_ff;
   assign best_slot  = slot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/priority_task_scheduler.sv =====
// Top level of the preemptive priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

// Task table of TASK_SLOTS entries held in one synchronous RAM, with a valid
// bit per slot in flops. An arrive word walks the valid bits from slot 0 and
// stores the task in the first free slot. A tick word reads every slot once
// through the single RAM read port and feeds one priority/age comparator,
// then re-reads the chosen slot and writes it back unless the task finishes.
// One word is worked on at a time; the next is taken while the previous
// result waits in the output register. preemptive_mode resets to 1; the user
// must write it through csr_wr_en only while the block is idle, as the block
// itself does not enforce this.

module priority_task_scheduler
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // task_id, task_priority, burst_length
   input  wire logic         req_tuser,   // op
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // run_id, time_now, turnaround, waiting
   output logic [2:0]        rsp_tuser,   // status
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data  // preemptive_mode
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TASK_SLOTS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FREE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_WAIT   = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   // slot table
   slot_entry_type slot_mem [TASK_SLOTS];
   slot_entry_type mem_q_ff;
   slot_entry_type mem_wdata;
   logic           mem_we;
   logic           mem_re;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic                  run_vld_ff, run_vld_in;
   logic [IDX_W-1:0]      run_slot_ff, run_slot_in;
   logic [PRIO_W-1:0]     run_prio_ff;
   logic [TIME_W-1:0]     clock_ff, clock_in;
   logic                  preempt_ff;
   logic [IDX_W-1:0]      cur_ff, cur_in;

   logic [ID_W-1:0]       req_id_ff, req_id_in;
   logic [PRIO_W-1:0]     req_prio_ff, req_prio_in;
   logic [BURST_W-1:0]    req_burst_ff, req_burst_in;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic [TIME_W-1:0]     turn_ff, turn_in;
   logic [TIME_W-1:0]     wait_ff, wait_in;

   // scan pipeline: RAM read, then candidate register, then picker
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_slot_ff, rd_slot_in;
   logic                  rd_sv_ff, rd_sv_in;
   logic                  cand_en_ff;
   cand_type              cand_ff;
   logic [IDX_W-1:0]      cand_slot_ff;
   logic                  pick_clr;

   logic                  best_found;
   logic [PRIO_W-1:0]     best_prio;
   logic [IDX_W-1:0]      best_slot;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [103:0]          rsp_tdata_ff;
   logic [2:0]            rsp_tuser_ff;
   logic                  rsp_load;

   logic                  run_ok;
   logic                  accept;

   pts_picker #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_picker (
      .clock      (clock),
      .reset      (reset),
      .clear      (pick_clr),
      .cand_en    (cand_en_ff),
      .cand       (cand_ff),
      .cand_slot  (cand_slot_ff),
      .best_found (best_found),
      .best_prio  (best_prio),
      .best_slot  (best_slot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign run_ok     = run_vld_ff && valid_ff[run_slot_ff];

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      run_vld_in    = run_vld_ff;
      run_slot_in   = run_slot_ff;
      clock_in      = clock_ff;
      cur_in        = cur_ff;
      req_id_in     = req_id_ff;
      req_prio_in   = req_prio_ff;
      req_burst_in  = req_burst_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      turn_in       = turn_ff;
      wait_in       = wait_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = rd_slot_ff;
      rd_sv_in      = rd_sv_ff;
      pick_clr      = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:0];
      mem_raddr     = idx_ff[IDX_W-1:0];
      mem_wdata     = mem_q_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_id_in    = req_tdata[7:0];
               req_prio_in  = req_tdata[15:8];
               req_burst_in = req_tdata[31:16];
               idx_in       = '0;
               turn_in      = '0;
               wait_in      = '0;
               if (req_tuser == OP_ARRIVE) begin
                  res_id_in = req_tdata[7:0];
                  state_in  = S_FREE;
               end else begin
                  res_id_in = '0;
                  pick_clr  = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end

         S_FREE: begin
            if (idx_ff == SCAN_END) begin
               res_status_in = ST_FULL;
               state_in      = S_EMIT;
            end else if (!valid_ff[idx_ff[IDX_W-1:0]]) begin
               mem_we            = 1'b1;
               mem_wdata.id        = req_id_ff;
               mem_wdata.prio      = req_prio_ff;
               mem_wdata.arrival   = clock_ff;
               mem_wdata.burst     = req_burst_ff;
               mem_wdata.remaining = req_burst_ff;
               valid_in[idx_ff[IDX_W-1:0]] = 1'b1;
               res_status_in = ST_STORED;
               state_in      = S_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_SCAN: begin
            if (idx_ff != SCAN_END) begin
               mem_re     = 1'b1;
               rd_vld_in  = 1'b1;
               rd_slot_in = idx_ff[IDX_W-1:0];
               rd_sv_in   = valid_ff[idx_ff[IDX_W-1:0]];
               idx_in     = idx_ff + 1'b1;
            end else if (!rd_vld_ff && !cand_en_ff) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            clock_in = clock_ff + 1'b1;
            if (run_ok) begin
               if (preempt_ff && best_found && best_prio < run_prio_ff) begin
                  cur_in = best_slot;
               end else begin
                  cur_in = run_slot_ff;
               end
               mem_re    = 1'b1;
               mem_raddr = cur_in;
               state_in  = S_FETCH;
            end else if (best_found) begin
               cur_in    = best_slot;
               mem_re    = 1'b1;
               mem_raddr = best_slot;
               state_in  = S_FETCH;
            end else begin
               run_vld_in    = 1'b0;
               res_status_in = ST_IDLE;
               state_in      = S_EMIT;
            end
         end

         S_FETCH: begin
            res_id_in = mem_q_ff.id;
            if (mem_q_ff.remaining <= BURST_W'(1)) begin
               valid_in[cur_ff] = 1'b0;
               run_vld_in       = 1'b0;
               turn_in          = clock_ff - mem_q_ff.arrival;
               res_status_in    = ST_DONE;
               state_in         = S_WAIT;
            end else begin
               mem_we              = 1'b1;
               mem_waddr           = cur_ff;
               mem_wdata.remaining = mem_q_ff.remaining - 1'b1;
               run_vld_in          = 1'b1;
               run_slot_in         = cur_ff;
               res_status_in       = ST_RAN;
               state_in            = S_EMIT;
            end
         end

         S_WAIT: begin
            wait_in  = turn_ff - TIME_W'(mem_q_ff.burst);
            state_in = S_EMIT;
         end

         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         run_vld_ff    <= 1'b0;
         run_slot_ff   <= '0;
         clock_ff      <= '0;
         preempt_ff    <= 1'b1;
         rd_vld_ff     <= 1'b0;
         cand_en_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         run_vld_ff    <= run_vld_in;
         run_slot_ff   <= run_slot_in;
         clock_ff      <= clock_in;
         rd_vld_ff     <= rd_vld_in;
         cand_en_ff    <= rd_vld_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
         idx_ff        <= idx_in;
         if (csr_wr_en) begin
            preempt_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      req_id_ff     <= req_id_in;
      req_prio_ff   <= req_prio_in;
      req_burst_ff  <= req_burst_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      turn_ff       <= turn_in;
      wait_ff       <= wait_in;
      rd_slot_ff    <= rd_slot_in;
      rd_sv_ff      <= rd_sv_in;

      cand_ff.vld   <= rd_sv_ff;
      cand_ff.prio  <= mem_q_ff.prio;
      cand_ff.age   <= clock_ff - mem_q_ff.arrival;
      cand_slot_ff  <= rd_slot_ff;
      // capture the running task's priority as its slot goes by
      if (rd_vld_ff && rd_slot_ff == run_slot_ff) begin
         run_prio_ff <= mem_q_ff.prio;
      end

      if (rsp_load) begin
         rsp_tdata_ff <= {wait_ff, turn_ff, clock_ff, res_id_ff};
         rsp_tuser_ff <= res_status_ff;
      end
   end

   // slot table RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= slot_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ===== test/pts_checker.sv =====
// Scoreboard for the priority task scheduler: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module pts_checker
   import pts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,   // task_id, task_priority, burst_length
   input  logic         req_tuser,   // op
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,   // run_id, time_now, turnaround, waiting
   input  logic [2:0]   rsp_tuser,   // status
   input  logic         csr_wr_en,
   input  logic         csr_wr_data, // preemptive_mode
   output int           failures,
   output int           pending
);

   localparam int NSLOT = TASK_SLOTS_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     run_id;
      logic [TIME_W-1:0]   time_now;
      logic [TIME_W-1:0]   turnaround;
      logic [TIME_W-1:0]   waiting;
   } sched_result_type;

   // task table as the scheduler should hold it
   logic               tbl_valid   [NSLOT];
   logic [ID_W-1:0]    tbl_id      [NSLOT];
   logic [PRIO_W-1:0]  tbl_prio    [NSLOT];
   logic [TIME_W-1:0]  tbl_arrival [NSLOT];
   logic [BURST_W-1:0] tbl_burst   [NSLOT];
   logic [BURST_W-1:0] tbl_left    [NSLOT];
   logic               cur_valid;
   int                 cur_slot;
   logic [TIME_W-1:0]  now_count;
   logic               preempt_on;

   sched_result_type results_due[$];
   int               results_seen;

   // a beats b: lower priority number, then older, then lower slot
   function automatic bit outranks(input int a, input int b);
      logic [TIME_W-1:0] age_a;
      logic [TIME_W-1:0] age_b;
      age_a = now_count - tbl_arrival[a];
      age_b = now_count - tbl_arrival[b];
      if (tbl_prio[a] != tbl_prio[b])
         return tbl_prio[a] < tbl_prio[b];
      if (age_a != age_b)
         return age_a > age_b;
      return a < b;
   endfunction

   // NSLOT when the table is empty
   function automatic int best_slot();
      int best;
      best = NSLOT;
      for (int i = 0; i < NSLOT; i++) begin
         if (tbl_valid[i] && (best == NSLOT || outranks(i, best)))
            best = i;
      end
      return best;
   endfunction

   function automatic sched_result_type schedule_word(input logic op,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [PRIO_W-1:0] prio,
                                                      input logic [BURST_W-1:0] burst);
      sched_result_type res;
      int pick;
      int slot;
      res = '0;
      if (op == OP_ARRIVE) begin
         res.status = ST_FULL;
         res.run_id = id;
         // take the lowest free slot
         for (int i = 0; i < NSLOT; i++) begin
            if (!tbl_valid[i] && res.status == ST_FULL) begin
               tbl_valid[i]   = 1'b1;
               tbl_id[i]      = id;
               tbl_prio[i]    = prio;
               tbl_arrival[i] = now_count;
               tbl_burst[i]   = burst;
               tbl_left[i]    = burst;
               res.status     = ST_STORED;
            end
         end
      end else begin
         pick = best_slot();
         if (cur_valid && tbl_valid[cur_slot]) begin
            slot = cur_slot;
            // displace only on a strictly smaller priority number
            if (preempt_on && pick < NSLOT && tbl_prio[pick] < tbl_prio[slot])
               slot = pick;
         end else begin
            slot = pick;
         end
         now_count = now_count + 1;
         if (slot >= NSLOT) begin
            cur_valid  = 1'b0;
            res.status = ST_IDLE;
         end else begin
            res.run_id = tbl_id[slot];
            if (tbl_left[slot] <= 1) begin
               tbl_left[slot]  = '0;
               tbl_valid[slot] = 1'b0;
               cur_valid       = 1'b0;
               res.turnaround  = now_count - tbl_arrival[slot];
               res.waiting     = res.turnaround - TIME_W'(tbl_burst[slot]);
               res.status      = ST_DONE;
            end else begin
               tbl_left[slot] = tbl_left[slot] - 1'b1;
               cur_valid      = 1'b1;
               cur_slot       = slot;
               res.status     = ST_RAN;
            end
         end
      end
      res.time_now = now_count;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] result %0d %s: got %0h, want %0h", $time, results_seen, what, got, want);
      failures++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      sched_result_type due;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++)
            tbl_valid[i] = 1'b0;
         cur_valid  = 1'b0;
         cur_slot   = 0;
         now_count  = '0;
         preempt_on = 1'b1;
         results_due.delete();
         results_seen = 0;
      end else begin
         if (csr_wr_en)
            preempt_on = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               report_mismatch("word with nothing due, status", 32'(rsp_tuser), '0);
            end else begin
               due = results_due.pop_front();
               check_field("status",     32'(rsp_tuser),      32'(due.status));
               check_field("run_id",     32'(rsp_tdata[7:0]), 32'(due.run_id));
               check_field("time_now",   rsp_tdata[39:8],     due.time_now);
               check_field("turnaround", rsp_tdata[71:40],    due.turnaround);
               check_field("waiting",    rsp_tdata[103:72],   due.waiting);
            end
         end
         if (req_tvalid && req_tready)
            results_due.push_back(schedule_word(req_tuser, req_tdata[7:0],
                                                req_tdata[15:8], req_tdata[31:16]));
      end
      pending = results_due.size();
   end

endmodule

// ===== test/priority_task_scheduler_tb.sv =====
// Testbench top for the priority task scheduler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module priority_task_scheduler_tb
   import pts_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 250;
   localparam int DRAIN_WAIT  = 40;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_wr_en;
   logic         csr_wr_data;
   int           failures;
   int           pending;

   // shared with the receiver: no idling while calm, one long stall on hold_off
   logic         calm;
   logic         hold_off;

   priority_task_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   always #1 clock = ~clock;

   task automatic send_word(input logic op, input logic [7:0] id, input logic [7:0] prio,
                            input logic [15:0] burst);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {burst, prio, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic        op;
      logic [7:0]  prio;
      logic [15:0] burst;
      op    = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_ARRIVE;
      // crowd the low priorities half the time so ties come up often
      prio  = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      burst = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(5, 40))
                                           : 16'($urandom_range(0, 4));
      send_word(op, 8'($urandom_range(0, 255)), prio, burst);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic run_phase(input logic mode, input int hold_at, input int calm_for);
      if (!mode) begin
         // retire the running task so the long burst cannot hold the processor
         send_word(OP_ARRIVE, 8'h77, 8'h00, 16'h0000);
         send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
      end
      wait_idle();
      csr_wr_data <= mode;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         calm = (n < calm_for);
         if (n == hold_at)
            hold_off = 1'b1;
         send_random();
      end
      calm = 1'b0;
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_ARRIVE;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      calm        = 1'b0;
      hold_off    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle tick on an empty table, ignored fields at their maximum
      send_word(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF);
      send_word(OP_ARRIVE, 8'h00, 8'h80, 16'h0001);
      send_word(OP_ARRIVE, 8'hFF, 8'hFF, 16'hFFFF);
      // zero burst finishes on its first unit
      send_word(OP_ARRIVE, 8'h5A, 8'h00, 16'h0000);
      send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
      send_word(OP_ARRIVE, 8'h01, 8'h10, 16'h0003);
      send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
      // equal priority must not displace the running task
      send_word(OP_ARRIVE, 8'h02, 8'h10, 16'h0002);
      send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
      // same priority and same arrival: lower slot wins, and it preempts
      send_word(OP_ARRIVE, 8'h03, 8'h08, 16'h0001);
      send_word(OP_ARRIVE, 8'h04, 8'h08, 16'h0001);
      send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
      // fill the table, the last word is dropped
      for (int k = 0; k < 12; k++)
         send_word(OP_ARRIVE, 8'hC0 + 8'(k), 8'h20 + 8'(k), 16'h0002);

      run_phase(1'b1, 100, 0);
      run_phase(1'b0, -1, 0);
      run_phase(1'b1, -1, 80);

      wait_idle();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // result side: random stalls per word, one long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
